FILE: sv/sqg_pkg.sv
package sqg_pkg;

  // Internal fixed point: unsigned Q30
  localparam int QB = 30;
  // Width of a value in [0, 1.0] in Q30
  localparam int WV_W = QB + 1;

  // Warp-mix register, Q1.16
  localparam int MIX_W = 17;
  localparam logic [MIX_W-1:0] MIX_ONE = 17'h10000;

  localparam int DEF_ANGLE_FRAC_BITS = 16;
  localparam int DEF_OUT_BITS = 16;

  // Warp polynomial coefficients, round(c * 2^30), lowest order first
  localparam int COEF_W = 32;
  localparam logic [COEF_W-1:0] WARP_COEF [6] = '{
    32'd843314857, 32'd693714077, 32'd680769380,
    32'd735677973, 32'd348983513, 32'd1631031862
  };

  // Point on the diagonal plus quadrant, passed between pipeline sections
  typedef struct packed {
    logic [WV_W-1:0] wu;
    logic [WV_W-1:0] ou;
    logic [1:0]      quad;
  } sqg_pair_t;

endpackage

FILE: sv/sqg_warp.sv
module sqg_warp #(
  parameter int ANGLE_FRAC_BITS = sqg_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [ANGLE_FRAC_BITS+1:0]       angle_i,
  input  logic [sqg_pkg::MIX_W-1:0]        mix_i,
  output logic                             valid_o,
  output sqg_pkg::sqg_pair_t               pair_o
);

  localparam int QB    = sqg_pkg::QB;
  localparam int WV_W  = sqg_pkg::WV_W;
  localparam int CW    = sqg_pkg::COEF_W;
  localparam int SH    = QB - ANGLE_FRAC_BITS;
  localparam int V2_W  = QB - 1;
  localparam int NST   = 10;
  localparam logic [QB-1:0]   HALF = {1'b1, {(QB-1){1'b0}}};
  localparam logic [WV_W-1:0] ONE  = {1'b1, {QB{1'b0}}};

  logic             vld_q [NST];
  logic [QB-1:0]    raw_q  [0:8];
  logic [1:0]       quad_q [0:8];
  logic [QB-1:0]    av_q   [0:6];
  logic             vneg_q [0:6];
  logic [V2_W-1:0]  v2_q   [1:5];
  logic [CW-1:0]    p_q    [2:6];
  logic [CW-1:0]    ad_q;
  logic             dneg_q [7:8];
  logic [CW-1:0]    d_q;
  sqg_pkg::sqg_pair_t pair_q;

  // stage 0 inputs
  logic [QB-1:0] raw_in;
  logic [QB-1:0] av_in;
  assign raw_in = {angle_i[ANGLE_FRAC_BITS-1:0], {SH{1'b0}}};
  assign av_in  = raw_in[QB-1] ? (raw_in - HALF) : (HALF - raw_in);

  // v^2
  logic [2*QB-1:0] v2_prod;
  assign v2_prod = (2*QB)'(av_q[0]) * (2*QB)'(av_q[0]);

  // Horner steps in v^2, one per stage
  logic [CW-1:0]        hp_d   [5];
  logic [V2_W+CW-1:0]   hprod  [5];
  for (genvar h = 0; h < 5; h++) begin : g_horner
    if (h == 0) begin : g_first
      assign hprod[h] = (V2_W+CW)'(v2_q[1]) * (V2_W+CW)'(sqg_pkg::WARP_COEF[5]);
    end else begin : g_next
      assign hprod[h] = (V2_W+CW)'(v2_q[h+1]) * (V2_W+CW)'(p_q[h+1]);
    end
    assign hp_d[h] = CW'(hprod[h] >> QB) + sqg_pkg::WARP_COEF[4-h];
  end

  // t = |v| * p, then difference to |v|
  logic [QB+CW-1:0] t_prod;
  logic [CW-1:0]    t_val;
  logic [CW-1:0]    av_ext;
  logic             t_ge;
  logic [CW-1:0]    ad_d;
  logic             dneg_d;
  assign t_prod = (QB+CW)'(av_q[6]) * (QB+CW)'(p_q[6]);
  assign t_val  = CW'(t_prod >> QB);
  assign av_ext = CW'(av_q[6]);
  assign t_ge   = t_val >= av_ext;
  assign ad_d   = t_ge ? (t_val - av_ext) : (av_ext - t_val);
  assign dneg_d = vneg_q[6] ? (t_ge && (ad_d != '0)) : !t_ge;

  // blend product
  logic [CW+sqg_pkg::MIX_W-1:0] d_prod;
  assign d_prod = (CW+sqg_pkg::MIX_W)'(ad_q) * (CW+sqg_pkg::MIX_W)'(mix_i);

  // blend, clamp, reverse
  logic [CW:0]     w_sum;
  logic [WV_W-1:0] w_val;
  sqg_pkg::sqg_pair_t pair_d;
  assign w_sum = (CW+1)'(raw_q[8]) + (CW+1)'(d_q);
  always_comb begin
    if (dneg_q[8]) begin
      w_val = (d_q >= CW'(raw_q[8])) ? '0 : (WV_W'(raw_q[8]) - WV_W'(d_q));
    end else begin
      w_val = (w_sum >= (CW+1)'(ONE)) ? ONE : w_sum[WV_W-1:0];
    end
    pair_d.quad = quad_q[8];
    if (quad_q[8][0]) begin
      pair_d.wu = ONE - w_val;
      pair_d.ou = w_val;
    end else begin
      pair_d.wu = w_val;
      pair_d.ou = ONE - w_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < NST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_q[0]  <= raw_in;
      quad_q[0] <= angle_i[ANGLE_FRAC_BITS+1:ANGLE_FRAC_BITS];
      av_q[0]   <= av_in;
      vneg_q[0] <= !raw_in[QB-1];
      for (int i = 1; i <= 8; i++) begin
        raw_q[i]  <= raw_q[i-1];
        quad_q[i] <= quad_q[i-1];
      end
      for (int i = 1; i <= 6; i++) begin
        av_q[i]   <= av_q[i-1];
        vneg_q[i] <= vneg_q[i-1];
      end
      v2_q[1] <= V2_W'(v2_prod >> QB);
      for (int i = 2; i <= 5; i++) v2_q[i] <= v2_q[i-1];
      for (int h = 0; h < 5; h++) p_q[h+2] <= hp_d[h];
      ad_q      <= ad_d;
      dneg_q[7] <= dneg_d;
      dneg_q[8] <= dneg_q[7];
      d_q       <= CW'(d_prod >> 16);
      pair_q    <= pair_d;
    end
  end

  assign valid_o = vld_q[NST-1];
  assign pair_o  = pair_q;

endmodule

FILE: sv/sqg_root.sv
module sqg_root (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  sqg_pkg::sqg_pair_t            pair_i,
  output logic                          valid_o,
  output sqg_pkg::sqg_pair_t            pair_o,
  output logic [sqg_pkg::WV_W-1:0]      root_o
);

  localparam int RW  = sqg_pkg::WV_W;
  localparam int XW  = 2 * RW;
  localparam int NST = RW + 2;

  logic               vld_q  [NST];
  sqg_pkg::sqg_pair_t pair_q [NST];
  logic [XW-1:0]      sqw_q;
  logic [XW-1:0]      sqo_q;
  logic [XW-1:0]      rem_q  [1:NST-1];
  logic [RW-1:0]      root_q [1:NST-1];

  logic [XW-1:0] rem_d  [2:NST-1];
  logic [RW-1:0] root_d [2:NST-1];

  // one result bit per stage, MSB first
  for (genvar g = 2; g < NST; g++) begin : g_bit
    localparam int K = NST - 1 - g;
    logic [XW-1:0] trial;
    assign trial = (XW'(root_q[g-1]) << (K + 1)) | (XW'(1) << (2 * K));
    always_comb begin
      if (rem_q[g-1] >= trial) begin
        rem_d[g]  = rem_q[g-1] - trial;
        root_d[g] = root_q[g-1] | (RW'(1) << K);
      end else begin
        rem_d[g]  = rem_q[g-1];
        root_d[g] = root_q[g-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < NST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pair_q[0] <= pair_i;
      for (int i = 1; i < NST; i++) pair_q[i] <= pair_q[i-1];
      sqw_q     <= XW'(pair_i.wu) * XW'(pair_i.wu);
      sqo_q     <= XW'(pair_i.ou) * XW'(pair_i.ou);
      rem_q[1]  <= sqw_q + sqo_q;
      root_q[1] <= '0;
      for (int i = 2; i < NST; i++) begin
        rem_q[i]  <= rem_d[i];
        root_q[i] <= root_d[i];
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign pair_o  = pair_q[NST-1];
  assign root_o  = root_q[NST-1];

endmodule

FILE: sv/sqg_div.sv
module sqg_div #(
  parameter int OUT_BITS = sqg_pkg::DEF_OUT_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  sqg_pkg::sqg_pair_t        pair_i,
  input  logic [sqg_pkg::WV_W-1:0]  root_i,
  output logic                      valid_o,
  output logic [1:0]                quad_o,
  output logic [OUT_BITS-1:0]       mag_o [2]
);

  localparam int SW  = sqg_pkg::WV_W;
  localparam int NW  = SW + OUT_BITS;
  localparam int NST = OUT_BITS + 1;

  logic                vld_q  [NST];
  logic [1:0]          quad_q [NST];
  logic [SW-1:0]       s_q    [NST];
  logic [SW-1:0]       rem_q  [NST][2];
  logic [OUT_BITS-1:0] low_q  [NST][2];
  logic [OUT_BITS-1:0] quo_q  [NST][2];

  // rounded numerator, lane 0 sine, lane 1 cosine
  logic [NW-1:0] num_d [2];
  assign num_d[0] = (NW'(pair_i.wu) << (OUT_BITS - 1)) + NW'(root_i >> 1);
  assign num_d[1] = (NW'(pair_i.ou) << (OUT_BITS - 1)) + NW'(root_i >> 1);

  logic [SW-1:0]       rem_d [1:NST-1][2];
  logic [OUT_BITS-1:0] quo_d [1:NST-1][2];

  // restoring division, one quotient bit per stage
  for (genvar j = 1; j < NST; j++) begin : g_step
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [SW:0] cand;
      assign cand = {rem_q[j-1][l], low_q[j-1][l][OUT_BITS-j]};
      always_comb begin
        if (cand >= {1'b0, s_q[j-1]}) begin
          rem_d[j][l] = SW'(cand - {1'b0, s_q[j-1]});
          quo_d[j][l] = {quo_q[j-1][l][OUT_BITS-2:0], 1'b1};
        end else begin
          rem_d[j][l] = cand[SW-1:0];
          quo_d[j][l] = {quo_q[j-1][l][OUT_BITS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < NST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q[0] <= pair_i.quad;
      s_q[0]    <= root_i;
      for (int l = 0; l < 2; l++) begin
        rem_q[0][l] <= SW'(num_d[l] >> OUT_BITS);
        low_q[0][l] <= num_d[l][OUT_BITS-1:0];
        quo_q[0][l] <= '0;
      end
      for (int i = 1; i < NST; i++) begin
        quad_q[i] <= quad_q[i-1];
        s_q[i]    <= s_q[i-1];
        for (int l = 0; l < 2; l++) begin
          rem_q[i][l] <= rem_d[i][l];
          low_q[i][l] <= low_q[i-1][l];
          quo_q[i][l] <= quo_d[i][l];
        end
      end
    end
  end

  assign valid_o  = vld_q[NST-1];
  assign quad_o   = quad_q[NST-1];
  assign mag_o[0] = quo_q[NST-1][0];
  assign mag_o[1] = quo_q[NST-1][1];

endmodule

FILE: sv/quadrant_sincos_generator_top.sv
// Stages from input transfer to result, in order:
//   10 warp stages, 33 normalize/root stages, OUT_BITS + 1 divide stages, 1 output stage.
// Throughput: one angle per cycle; a 2-entry output buffer keeps accepting while
//   one result waits, the whole pipeline stalls only when both entries are full.
// Reset (rst_ni low, asynchronous): pipeline and buffer empty, warp_mix = 1.0.
module quadrant_sincos_generator_top #(
  parameter int ANGLE_FRAC_BITS = sqg_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int OUT_BITS        = sqg_pkg::DEF_OUT_BITS,
  localparam int IN_TDW  = ((ANGLE_FRAC_BITS + 2 + 7) / 8) * 8,
  localparam int OUT_TDW = ((2 * OUT_BITS + 7) / 8) * 8,
  localparam int CFG_DW  = ((sqg_pkg::MIX_W + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input angles
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [IN_TDW-1:0]  s_axis_tdata,   // [ANGLE_FRAC_BITS+1:0] angle
  // results
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [OUT_TDW-1:0] m_axis_tdata,   // sine_value, then cosine_value
  // warp_mix register write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_DW-1:0]  cfg_data_i      // [16:0] warp_mix
);

  localparam int MIX_W = sqg_pkg::MIX_W;
  localparam logic [OUT_BITS-1:0] FULL = {1'b1, {(OUT_BITS-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // warp_mix register, saturated to 1.0 on write
  // ---------------------------------------------------------------------------
  logic [MIX_W-1:0] mix_q, mix_d;
  assign cfg_ready_o = 1'b1;
  always_comb begin
    mix_d = mix_q;
    if (cfg_valid_i) begin
      mix_d = (cfg_data_i[MIX_W-1:0] > sqg_pkg::MIX_ONE) ? sqg_pkg::MIX_ONE
                                                         : cfg_data_i[MIX_W-1:0];
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mix_q <= sqg_pkg::MIX_ONE;
    else         mix_q <= mix_d;
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: all stages move together while the buffer has room
  // ---------------------------------------------------------------------------
  logic [1:0] cnt_q, cnt_d;
  logic       adv;
  assign adv           = (cnt_q != 2'd2) || m_axis_tready;
  assign s_axis_tready = adv;

  logic               warp_vld, root_vld, div_vld;
  sqg_pkg::sqg_pair_t warp_pair, root_pair;
  logic [sqg_pkg::WV_W-1:0] root_val;
  logic [1:0]         div_quad;
  logic [OUT_BITS-1:0] div_mag [2];

  sqg_warp #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_warp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid),
    .angle_i (s_axis_tdata[ANGLE_FRAC_BITS+1:0]),
    .mix_i   (mix_q),
    .valid_o (warp_vld),
    .pair_o  (warp_pair)
  );

  sqg_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (warp_vld),
    .pair_i  (warp_pair),
    .valid_o (root_vld),
    .pair_o  (root_pair),
    .root_o  (root_val)
  );

  sqg_div #(.OUT_BITS(OUT_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (root_vld),
    .pair_i  (root_pair),
    .root_i  (root_val),
    .valid_o (div_vld),
    .quad_o  (div_quad),
    .mag_o   (div_mag)
  );

  // ---------------------------------------------------------------------------
  // Sign and saturation: sine negative in quadrants 2,3; cosine in 1,2
  // ---------------------------------------------------------------------------
  logic [OUT_BITS-1:0] enc [2];
  logic                neg [2];
  assign neg[0] = div_quad[1];
  assign neg[1] = div_quad[1] ^ div_quad[0];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [OUT_BITS-1:0] m;
      m = (div_mag[l] > FULL) ? FULL : div_mag[l];
      if (neg[l])          enc[l] = OUT_BITS'(0) - m;
      else if (m == FULL)  enc[l] = FULL - OUT_BITS'(1);
      else                 enc[l] = m;
    end
  end

  logic [OUT_TDW-1:0] push_data;
  assign push_data = OUT_TDW'({enc[1], enc[0]});

  // ---------------------------------------------------------------------------
  // Two-entry output buffer
  // ---------------------------------------------------------------------------
  logic [OUT_TDW-1:0] ent0_q, ent1_q;
  logic push, pop;
  assign push = div_vld && adv;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop)      cnt_d = cnt_q + 2'd1;
    else if (!push && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 2'd0;
    else         cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ent0_q <= (cnt_q == 2'd2) ? ent1_q : push_data;
    end else if (push && (cnt_q == 2'd0)) begin
      ent0_q <= push_data;
    end
    if (push && (((cnt_q == 2'd1) && !pop) || ((cnt_q == 2'd2) && pop))) begin
      ent1_q <= push_data;
    end
  end

  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = ent0_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer count out of range");

  a_mix_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_q <= sqg_pkg::MIX_ONE) else $error("warp_mix above 1.0");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while buffer full");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && pop) |=> cnt_q == $past(cnt_q))
    else $error("buffer count moved on push with pop");

endmodule
